// File: src/assert_macros.svh
// assertion macros shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked while out of reset
`define DTM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked at every edge, reset included
`define DTM_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: src/dtm_pkg.sv
`default_nettype none
package dtm_pkg;

  localparam int AGE_WIDTH_DEF = 16;
  localparam int TIMEOUT_W     = 16;
  localparam int SIDE_DIFF_W   = 8;
  localparam int DRIVE_W       = 8;
  localparam int CFG_DATA_W    = 16;
  localparam int CFG_IDX_W     = 2;
  // wide enough for the cross-saturating shifts
  localparam int MIX_W         = 12;

  localparam logic [TIMEOUT_W-1:0]   TIMEOUT_RST   = TIMEOUT_W'(6);
  localparam logic [SIDE_DIFF_W-1:0] SIDE_DIFF_RST = SIDE_DIFF_W'(50);

  localparam logic signed [MIX_W-1:0] DRIVE_MAX = MIX_W'(100);
  localparam logic signed [MIX_W-1:0] DRIVE_MIN = -MIX_W'(100);

  // request kinds
  localparam logic [1:0] KIND_THRUST = 2'd0;
  localparam logic [1:0] KIND_RUDDER = 2'd1;
  localparam logic [1:0] KIND_TICK   = 2'd2;

  // config register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_NEW_MODE  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT   = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_SIDE_DIFF = CFG_IDX_W'(2);

  typedef struct packed {
    logic [1:0]               kind;
    logic signed [DRIVE_W-1:0] command_value;
  } in_payload_t;

  typedef struct packed {
    logic signed [DRIVE_W-1:0] left_drive;
    logic signed [DRIVE_W-1:0] right_drive;
    logic                      timed_out;
  } out_payload_t;

  // command levels and freshness captured when a tick is taken
  typedef struct packed {
    logic signed [DRIVE_W-1:0] thrust;
    logic signed [DRIVE_W-1:0] rudder;
    logic                      stale;
  } snap_t;

  function automatic logic signed [DRIVE_W-1:0] clamp_drive(
    input logic signed [MIX_W-1:0] v
  );
    logic signed [MIX_W-1:0] c;
    c = v;
    if (v > DRIVE_MAX) c = DRIVE_MAX;
    if (v < DRIVE_MIN) c = DRIVE_MIN;
    return c[DRIVE_W-1:0];
  endfunction

endpackage
`default_nettype wire

// File: src/dtm_state.sv
`default_nettype none
module dtm_state #(
  parameter int AGE_WIDTH = dtm_pkg::AGE_WIDTH_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             req_acc,
  input  wire dtm_pkg::in_payload_t             req,
  input  wire logic [dtm_pkg::TIMEOUT_W-1:0]    timeout,
  output dtm_pkg::snap_t                        snap
);

  localparam int CMP_W = (AGE_WIDTH > dtm_pkg::TIMEOUT_W) ? AGE_WIDTH : dtm_pkg::TIMEOUT_W;
  localparam logic [AGE_WIDTH-1:0] AGE_SAT = {AGE_WIDTH{1'b1}};

  logic signed [dtm_pkg::DRIVE_W-1:0] thrust_r, thrust_nxt;
  logic signed [dtm_pkg::DRIVE_W-1:0] rudder_r, rudder_nxt;
  logic [AGE_WIDTH-1:0] thrust_age_r, thrust_age_nxt;
  logic [AGE_WIDTH-1:0] rudder_age_r, rudder_age_nxt;
  logic [CMP_W-1:0]     tmo_ext;

  always_comb begin
    thrust_nxt     = thrust_r;
    rudder_nxt     = rudder_r;
    thrust_age_nxt = thrust_age_r;
    rudder_age_nxt = rudder_age_r;
    if (req_acc) begin
      case (req.kind)
        dtm_pkg::KIND_THRUST: begin
          thrust_nxt     = req.command_value;
          thrust_age_nxt = '0;
        end
        dtm_pkg::KIND_RUDDER: begin
          rudder_nxt     = req.command_value;
          rudder_age_nxt = '0;
        end
        dtm_pkg::KIND_TICK: begin
          // ages saturate at all ones
          if (thrust_age_r != AGE_SAT) thrust_age_nxt = thrust_age_r + AGE_WIDTH'(1);
          if (rudder_age_r != AGE_SAT) rudder_age_nxt = rudder_age_r + AGE_WIDTH'(1);
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thrust_r     <= '0;
      rudder_r     <= '0;
      thrust_age_r <= AGE_SAT;
      rudder_age_r <= AGE_SAT;
    end else begin
      thrust_r     <= thrust_nxt;
      rudder_r     <= rudder_nxt;
      thrust_age_r <= thrust_age_nxt;
      rudder_age_r <= rudder_age_nxt;
    end
  end

  assign tmo_ext     = CMP_W'(timeout);
  assign snap.thrust = thrust_r;
  assign snap.rudder = rudder_r;
  assign snap.stale  = (CMP_W'(thrust_age_r) >= tmo_ext) || (CMP_W'(rudder_age_r) >= tmo_ext);

endmodule
`default_nettype wire

// File: src/dtm_mix.sv
`default_nettype none
module dtm_mix (
  input  wire dtm_pkg::snap_t                      snap,
  input  wire logic                                new_mode,
  input  wire logic [dtm_pkg::SIDE_DIFF_W-1:0]     side_lim,
  output dtm_pkg::out_payload_t                    res
);

  localparam int DW = dtm_pkg::DRIVE_W;
  localparam int MW = dtm_pkg::MIX_W;

  logic signed [MW-1:0]   l_raw, r_raw, l_x, r_x;
  logic signed [DW-1:0]   left_c, right_c, left_f, right_f;
  logic signed [DW:0]     diff;
  logic [DW:0]            diff_abs;
  logic signed [DW+1:0]   lim_s, left_m, right_m;

  always_comb begin
    l_raw = MW'(snap.thrust) + MW'(snap.rudder);
    r_raw = MW'(snap.thrust) - MW'(snap.rudder);

    // move the excess of one side onto the other
    l_x = l_raw;
    r_x = r_raw;
    if (l_raw > dtm_pkg::DRIVE_MAX) r_x = r_x - (l_raw - dtm_pkg::DRIVE_MAX);
    if (l_raw < dtm_pkg::DRIVE_MIN) r_x = r_x - (l_raw - dtm_pkg::DRIVE_MIN);
    if (r_x > dtm_pkg::DRIVE_MAX) l_x = l_x - (r_x - dtm_pkg::DRIVE_MAX);
    if (r_x < dtm_pkg::DRIVE_MIN) l_x = l_x - (r_x - dtm_pkg::DRIVE_MIN);

    if (new_mode) begin
      left_c  = dtm_pkg::clamp_drive(l_x);
      right_c = dtm_pkg::clamp_drive(r_x);
    end else begin
      left_c  = dtm_pkg::clamp_drive(l_raw);
      right_c = dtm_pkg::clamp_drive(r_raw);
    end

    // side difference limit, new mode only
    diff     = (DW+1)'(left_c) - (DW+1)'(right_c);
    diff_abs = diff[DW] ? (DW+1)'(-diff) : diff;
    lim_s    = $signed({2'b00, side_lim});
    left_m   = (DW+2)'(right_c) - lim_s;
    right_m  = (DW+2)'(left_c) - lim_s;
    left_f   = left_c;
    right_f  = right_c;
    if (new_mode && (diff_abs > {1'b0, side_lim})) begin
      if (left_c > right_c) right_f = right_m[DW-1:0];
      else                  left_f  = left_m[DW-1:0];
    end

    res.left_drive  = snap.stale ? '0 : left_f;
    res.right_drive = snap.stale ? '0 : right_f;
    res.timed_out   = snap.stale;
  end

endmodule
`default_nettype wire

// File: src/differential_thrust_mixer.sv
// differential thrust mixer: takes thrust, rudder and tick requests on in_data and answers
// each tick with one result of left and right drive in percent (-100..100) plus a timeout
// flag; thrust and rudder requests only update the held command and give no result. a
// request is taken every cycle when the result side keeps up, and a tick's result goes
// through the capture register, which holds the command snapshot while the mix logic
// works out the drive, and then the result register, which drives out_valid and holds
// while out_ready is low. the command ages count ticks and saturate; a tick with either
// age at or above timeout_ticks sends zero drive with timed_out set. config registers
// (0 new_style_mode, 1 timeout_ticks, 2 max_side_diff) are written through
// cfg_we/cfg_index/cfg_wdata; they must be written while no result is pending, which
// the block itself does not enforce.
`default_nettype none
`include "assert_macros.svh"
module differential_thrust_mixer #(
  parameter int AGE_WIDTH = dtm_pkg::AGE_WIDTH_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  // request channel
  input  wire logic                              in_valid,
  output      logic                              in_ready,
  input  wire dtm_pkg::in_payload_t              in_data,
  // result channel
  output      logic                              out_valid,
  input  wire logic                              out_ready,
  output      dtm_pkg::out_payload_t             out_data,
  // config write port
  input  wire logic                              cfg_we,
  input  wire logic [dtm_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [dtm_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

  // config registers
  logic                                new_mode_r;
  logic [dtm_pkg::TIMEOUT_W-1:0]       timeout_r;
  logic [dtm_pkg::SIDE_DIFF_W-1:0]     side_lim_r;

  // capture stage and result register
  dtm_pkg::snap_t        snap_now, snap_r;
  logic                  cap_vld_r, cap_vld_nxt;
  dtm_pkg::out_payload_t mix_res, out_data_r;
  logic                  out_vld_r, out_vld_nxt;

  logic req_acc, tick_acc, cap_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      new_mode_r <= 1'b0;
      timeout_r  <= dtm_pkg::TIMEOUT_RST;
      side_lim_r <= dtm_pkg::SIDE_DIFF_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        dtm_pkg::CFG_NEW_MODE:  new_mode_r <= cfg_wdata[0];
        dtm_pkg::CFG_TIMEOUT:   timeout_r  <= cfg_wdata[dtm_pkg::TIMEOUT_W-1:0];
        dtm_pkg::CFG_SIDE_DIFF: side_lim_r <= cfg_wdata[dtm_pkg::SIDE_DIFF_W-1:0];
        default: ;
      endcase
    end
  end

  // capture advances when the result register is free or being drained
  assign cap_adv  = cap_vld_r && (!out_vld_r || out_ready);
  assign in_ready = !cap_vld_r || cap_adv;
  assign req_acc  = in_valid && in_ready;
  assign tick_acc = req_acc && (in_data.kind == dtm_pkg::KIND_TICK);

  // held commands and their ages, snapshot is taken before this tick ages them
  dtm_state #(
    .AGE_WIDTH (AGE_WIDTH)
  ) u_state (
    .clk     (clk),
    .rst_n   (rst_n),
    .req_acc (req_acc),
    .req     (in_data),
    .timeout (timeout_r),
    .snap    (snap_now)
  );

  always_comb begin
    cap_vld_nxt = cap_vld_r;
    if (cap_adv)  cap_vld_nxt = 1'b0;
    if (tick_acc) cap_vld_nxt = 1'b1;
    out_vld_nxt = out_vld_r;
    if (out_ready) out_vld_nxt = 1'b0;
    if (cap_adv)   out_vld_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_vld_r <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      cap_vld_r <= cap_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (tick_acc) snap_r <= snap_now;
    if (cap_adv)  out_data_r <= mix_res;
  end

  // arcade mix with optional cross saturation and side difference limit
  dtm_mix u_mix (
    .snap     (snap_r),
    .new_mode (new_mode_r),
    .side_lim (side_lim_r),
    .res      (mix_res)
  );

  assign out_valid = out_vld_r;
  assign out_data  = out_data_r;

  // terms used by the checks below
  logic stale_out, out_zero, drive_ok, pipe_idle;
  assign stale_out = out_vld_r && out_data_r.timed_out;
  assign out_zero  = (out_data_r.left_drive == '0) && (out_data_r.right_drive == '0);
  assign drive_ok  = (out_data_r.left_drive <= 8'sd100) && (out_data_r.left_drive >= -8'sd100)
                  && (out_data_r.right_drive <= 8'sd100)
                  && (out_data_r.right_drive >= -8'sd100);
  assign pipe_idle = !cap_vld_r && !out_vld_r;

  // a stale tick never drives the motors
  `DTM_ASSERT(a_stale_zero, stale_out |-> out_zero, "timeout result with nonzero drive")
  // drive stays inside the percent range
  `DTM_ASSERT(a_drive_range, out_vld_r |-> drive_ok, "drive out of range")
  // an accepted tick always lands in the capture stage
  `DTM_ASSERT(a_tick_captured, tick_acc |=> cap_vld_r, "tick lost at capture")
  // nothing pending right after reset
  `DTM_ASSERT_ALWAYS(a_reset_idle, !$past(rst_n) |-> pipe_idle, "pipeline busy after reset")

endmodule
`default_nettype wire

// File: sim/dtm_mix_sb_pkg.sv
package dtm_mix_sb_pkg;
  import dtm_pkg::*;

  // the one kind code the block ignores
  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam int PCT_LIMIT = 100;
  localparam int MAX_PRINTED = 100;

  class drive_mix_scoreboard;
    bit                         new_mode;
    bit [TIMEOUT_W-1:0]         timeout;
    bit [SIDE_DIFF_W-1:0]       side_diff;
    logic signed [DRIVE_W-1:0]  thrust_cmd;
    logic signed [DRIVE_W-1:0]  rudder_cmd;
    bit [AGE_WIDTH_DEF-1:0]     thrust_age;
    bit [AGE_WIDTH_DEF-1:0]     rudder_age;
    out_payload_t               expected_drive_q[$];
    int                         mismatches;
    int                         results_seen;

    function new();
      new_mode     = 1'b0;
      timeout      = TIMEOUT_RST;
      side_diff    = SIDE_DIFF_RST;
      thrust_cmd   = '0;
      rudder_cmd   = '0;
      thrust_age   = '1;
      rudder_age   = '1;
      mismatches   = 0;
      results_seen = 0;
    endfunction

    function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_NEW_MODE:  new_mode  = data[0];
        CFG_TIMEOUT:   timeout   = data[TIMEOUT_W-1:0];
        CFG_SIDE_DIFF: side_diff = data[SIDE_DIFF_W-1:0];
        default: ;
      endcase
    endfunction

    function int pending();
      return expected_drive_q.size();
    endfunction

    function int clamp_pct(int v);
      if (v > PCT_LIMIT) return PCT_LIMIT;
      if (v < -PCT_LIMIT) return -PCT_LIMIT;
      return v;
    endfunction

    // left/right drive for a tick taken with the current commands and ages
    function out_payload_t mix_drive();
      out_payload_t res;
      int t, r, lft, rgt, lim, d;
      res = '0;
      if (thrust_age >= timeout || rudder_age >= timeout) begin
        res.timed_out = 1'b1;
        return res;
      end
      t   = thrust_cmd;
      r   = rudder_cmd;
      lft = t + r;
      rgt = t - r;
      if (new_mode) begin
        lim = side_diff;
        // push the excess of one side onto the other
        if (lft > PCT_LIMIT) rgt -= lft - PCT_LIMIT;
        if (lft < -PCT_LIMIT) rgt -= lft + PCT_LIMIT;
        if (rgt > PCT_LIMIT) lft -= rgt - PCT_LIMIT;
        if (rgt < -PCT_LIMIT) lft -= rgt + PCT_LIMIT;
        lft = clamp_pct(lft);
        rgt = clamp_pct(rgt);
        d = lft - rgt;
        if (d < 0) d = -d;
        if (d > lim) begin
          if (lft > rgt) rgt = lft - lim;
          else lft = rgt - lim;
        end
      end else begin
        lft = clamp_pct(lft);
        rgt = clamp_pct(rgt);
      end
      res.left_drive  = lft[DRIVE_W-1:0];
      res.right_drive = rgt[DRIVE_W-1:0];
      return res;
    endfunction

    function void note_request(in_payload_t req);
      case (req.kind)
        KIND_THRUST: begin
          thrust_cmd = req.command_value;
          thrust_age = '0;
        end
        KIND_RUDDER: begin
          rudder_cmd = req.command_value;
          rudder_age = '0;
        end
        KIND_TICK: begin
          expected_drive_q.push_back(mix_drive());
          if (thrust_age != '1) thrust_age++;
          if (rudder_age != '1) rudder_age++;
        end
        default: ;
      endcase
    endfunction

    task report_mismatch(string what);
      mismatches++;
      if (mismatches <= MAX_PRINTED)
        $display("[%0t] result %0d mismatch: %s", $time, results_seen, what);
    endtask

    task check_result(out_payload_t got);
      out_payload_t want;
      results_seen++;
      if (expected_drive_q.size() == 0) begin
        report_mismatch($sformatf("unexpected result left %0d right %0d timed_out %0b",
                                  got.left_drive, got.right_drive, got.timed_out));
        return;
      end
      want = expected_drive_q.pop_front();
      if (got.left_drive !== want.left_drive)
        report_mismatch($sformatf("left_drive got %0d want %0d",
                                  got.left_drive, want.left_drive));
      if (got.right_drive !== want.right_drive)
        report_mismatch($sformatf("right_drive got %0d want %0d",
                                  got.right_drive, want.right_drive));
      if (got.timed_out !== want.timed_out)
        report_mismatch($sformatf("timed_out got %b want %b",
                                  got.timed_out, want.timed_out));
    endtask
  endclass

endpackage

// File: sim/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import dtm_pkg::*;
  import dtm_mix_sb_pkg::*;

  // cycles to let the two-stage pipe go quiet before a config write
  localparam int SETTLE_CYCLES = 4;
  // watchdog limit, well above the slowest legal run
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int RANDOM_PHASES = 10;
  localparam int PHASE_REQUESTS = 125;

  logic                   clk = 1'b0;
  logic                   rst_n;
  logic                   in_valid;
  logic                   in_ready;
  in_payload_t            in_data;
  logic                   out_valid;
  logic                   out_ready;
  out_payload_t           out_data;
  logic                   cfg_we;
  logic [CFG_IDX_W-1:0]   cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_wdata;

  int unsigned            cycle_count = 0;
  int                     burst_left;
  drive_mix_scoreboard    sb = new();

  always #5 clk = ~clk;

  differential_thrust_mixer u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // watchdog: a hung handshake or a missing result ends up here
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still expected",
               cycle_count, sb.pending());
      $display("Test completed with failures");
      $finish;
    end
  end

  // result monitor, sampled on the rising edge before the dut updates
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_result(out_data);
  end

  // result side backpressure: its own pattern, independent of the sender
  initial begin : result_stall
    int mode;
    int span;
    int i;
    out_ready = 1'b0;
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(10, 60);
      for (i = 0; i < span; i++) begin
        @(negedge clk);
        case (mode)
          0: out_ready <= 1'b1;                          // full rate
          1: out_ready <= ($urandom_range(0, 1) == 1);   // coin flip
          2: out_ready <= ($urandom_range(0, 5) != 0);   // mostly ready
          default: out_ready <= ((i % 12) >= 9);         // long stalls
        endcase
      end
    end
  end

  // hold valid low to put a gap between requests
  task automatic gap_cycles(int n);
    repeat (n) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
  endtask

  // one request on the input channel, with burst and gap shaping
  task automatic send_request(logic [1:0] kind, logic signed [DRIVE_W-1:0] value);
    in_payload_t req;
    req.kind          = kind;
    req.command_value = value;
    if (burst_left == 0) begin
      // sometimes back to back bursts with no gap at all
      if ($urandom_range(0, 3) != 0) gap_cycles($urandom_range(1, 8));
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk); while (in_ready !== 1'b1);
    sb.note_request(req);
  endtask

  // tick carries a junk value, the block must ignore it
  task automatic send_tick();
    send_request(KIND_TICK, DRIVE_W'($urandom));
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    sb.set_register(idx, data);
  endtask

  task automatic apply_config(bit mode, logic [TIMEOUT_W-1:0] tmo,
                              logic [SIDE_DIFF_W-1:0] diff);
    write_reg(CFG_NEW_MODE, CFG_DATA_W'(mode));
    write_reg(CFG_TIMEOUT, CFG_DATA_W'(tmo));
    write_reg(CFG_SIDE_DIFF, CFG_DATA_W'(diff));
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // stop sending, wait for every tick's result, then let the pipe settle
  task automatic drain(int extra);
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  // command percent: corners around the clamp, mid values, or anything
  function automatic logic signed [DRIVE_W-1:0] pick_pct();
    logic signed [DRIVE_W-1:0] corner[10] = '{-128, 127, -101, -100, -99, 99, 100, 101, 0, -1};
    case ($urandom_range(0, 9))
      0, 1:    return corner[$urandom_range(0, 9)];
      2, 3, 4: return DRIVE_W'(int'($urandom_range(0, 120)) - 60);
      default: return DRIVE_W'($urandom);
    endcase
  endfunction

  function automatic logic [1:0] pick_kind();
    case ($urandom_range(0, 2))
      0:       return KIND_THRUST;
      1:       return KIND_RUDDER;
      default: return KIND_TICK;
    endcase
  endfunction

  // random traffic: mostly command pairs followed by a few ticks, the rest
  // loose requests and ignored kinds; ignored requests are not counted
  task automatic run_traffic(int n);
    int counted;
    int pick;
    counted = 0;
    while (counted < n) begin
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        if ($urandom_range(0, 9) != 0) begin
          send_request(KIND_THRUST, pick_pct());
          counted++;
        end
        if ($urandom_range(0, 9) != 0) begin
          send_request(KIND_RUDDER, pick_pct());
          counted++;
        end
        repeat ($urandom_range(1, 8)) begin
          send_tick();
          counted++;
        end
      end else if (pick < 92) begin
        send_request(pick_kind(), pick_pct());
        counted++;
      end else begin
        send_request(KIND_UNUSED, pick_pct());
      end
    end
  endtask

  // random setting for later phases, timeouts mostly short enough to expire
  task automatic random_config();
    logic [TIMEOUT_W-1:0] tmo;
    if ($urandom_range(0, 5) == 0) tmo = TIMEOUT_W'($urandom);
    else tmo = TIMEOUT_W'($urandom_range(1, 12));
    apply_config($urandom_range(0, 1), tmo, SIDE_DIFF_W'($urandom_range(0, 200)));
  endtask

  initial begin : stimulus
    int p;
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_data    = '0;
    cfg_we     = 1'b0;
    cfg_index  = '0;
    cfg_wdata  = '0;
    burst_left = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset settings, ages start saturated so the first tick is stale
    send_tick();
    drain(SETTLE_CYCLES);

    // widest timeout: a saturated age still counts as stale
    apply_config(1'b0, '1, SIDE_DIFF_RST);
    send_tick();
    send_request(KIND_THRUST, 127);
    send_tick();                           // rudder still saturated
    send_request(KIND_RUDDER, 127);
    send_tick();                           // simple clamp on the left side
    send_request(KIND_THRUST, -128);
    send_request(KIND_RUDDER, -128);
    send_request(KIND_UNUSED, -1);         // ignored, no state change
    send_tick();
    drain(SETTLE_CYCLES);

    // short timeout: fresh for three ticks, then stale
    apply_config(1'b0, 3, SIDE_DIFF_RST);
    send_request(KIND_THRUST, 5);
    send_request(KIND_RUDDER, -7);
    repeat (4) send_tick();
    drain(SETTLE_CYCLES);

    // new mode with no side difference allowed, cross-saturation both ways
    apply_config(1'b1, 6, '0);
    send_request(KIND_THRUST, 127);
    send_request(KIND_RUDDER, 127);
    send_tick();
    send_request(KIND_THRUST, -128);
    send_request(KIND_RUDDER, 127);
    send_tick();
    drain(SETTLE_CYCLES);

    // zero timeout: every tick times out even right after a command
    apply_config(1'b1, '0, 200);
    send_request(KIND_THRUST, 0);
    send_tick();

    for (p = 0; p < RANDOM_PHASES; p++) begin
      drain(SETTLE_CYCLES);
      case (p)
        0:       apply_config(1'b0, 6, 50);
        1:       apply_config(1'b1, 6, 200);
        2:       apply_config(1'b1, 4, '0);
        3:       apply_config(1'b1, '1, SIDE_DIFF_W'($urandom_range(0, 200)));
        4:       apply_config(1'b0, '0, 200);
        default: random_config();
      endcase
      run_traffic(PHASE_REQUESTS);
    end

    drain(SETTLE_CYCLES * 3);
    if (sb.mismatches == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
